// ===== hw/rtl/assert_macros.svh =====
// assertion helpers, clocked on clk and held off while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication property
`define CSGDM_ASSERT_IMPL(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication property
`define CSGDM_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

// at most one bit of a vector set
`define CSGDM_ASSERT_ONEHOT0(lbl, vec, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) $onehot0(vec)) \
    else $error(msg);

`endif

// ===== hw/rtl/csgdm_pkg.sv =====
`default_nettype none
package csgdm_pkg;

  // list sizing
  localparam int LIST_DEPTH = 16;
  localparam int TAG_BITS   = 16;
  localparam int MAX_OUT    = 32;

  localparam int DIST_W   = 32;
  localparam int TAG_W    = 16;
  localparam int TAG_KEEP = (TAG_BITS < TAG_W) ? TAG_BITS : TAG_W;
  localparam int IDX_W    = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CNT_W    = $clog2(LIST_DEPTH + 1);
  localparam int NOUT_W   = $clog2(MAX_OUT + 1);

  // input command codes
  typedef enum logic [1:0] {
    CMD_LOAD_FIRST  = 2'd0,
    CMD_LOAD_SECOND = 2'd1,
    CMD_RUN         = 2'd2,
    CMD_NONE        = 2'd3
  } csgdm_op_t;

  // one stored hit
  typedef struct packed {
    logic signed [DIST_W-1:0] distance;
    logic [TAG_KEEP-1:0]      tag;
  } csgdm_hit_t;

  // controller to datapath
  typedef struct packed {
    logic load_first;
    logic load_second;
    logic start;
    logic step;
    logic finish;
  } csgdm_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic done;
    logic stall;
    logic out_busy;
  } csgdm_stat_t;

endpackage
`default_nettype wire

// ===== hw/rtl/csgdm_in_if.sv =====
`default_nettype none
interface csgdm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic signed [31:0] hit_distance;
  logic [15:0] hit_tag;

  modport source (output valid, output command, output hit_distance, output hit_tag,
                  input ready);
  modport sink   (input valid, input command, input hit_distance, input hit_tag,
                  output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/csgdm_out_if.sv =====
`default_nettype none
interface csgdm_out_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] out_distance;
  logic [15:0] out_tag;
  logic        hit_valid;
  logic        overflow_seen;
  logic        last_item;

  modport source (output valid, output out_distance, output out_tag, output hit_valid,
                  output overflow_seen, output last_item, input ready);
  modport sink   (input valid, input out_distance, input out_tag, input hit_valid,
                  input overflow_seen, input last_item, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/csgdm_ctrl.sv =====
`default_nettype none
module csgdm_ctrl
  import csgdm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic [1:0]  in_command,
  output logic             in_ready,
  input  wire csgdm_stat_t stat,
  output csgdm_cmd_t       cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_MERGE,
    ST_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r;
  logic   accept;

  assign in_ready = in_ready_r;
  assign accept   = in_valid && in_ready_r;

  // command decode
  always_comb begin
    cmd = '0;
    if (accept) begin
      case (in_command)
        CMD_LOAD_FIRST:  cmd.load_first  = 1'b1;
        CMD_LOAD_SECOND: cmd.load_second = 1'b1;
        CMD_RUN:         cmd.start       = 1'b1;
        default:         cmd             = '0;
      endcase
    end
    cmd.step   = (state_r == ST_MERGE) && !stat.done && !stat.stall;
    cmd.finish = (state_r == ST_FINISH) && !stat.out_busy;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (cmd.start) state_nxt = ST_READ;
      ST_READ:   state_nxt = ST_MERGE;
      ST_MERGE: begin
        if (stat.done) state_nxt = ST_FINISH;
        else if (!stat.stall) state_nxt = ST_READ;
      end
      ST_FINISH: if (!stat.out_busy) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // state and registered ready
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      in_ready_r <= 1'b1;
    end else begin
      state_r    <= state_nxt;
      in_ready_r <= (state_nxt == ST_IDLE);
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/csgdm_datapath.sv =====
`default_nettype none
module csgdm_datapath
  import csgdm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic signed [DIST_W-1:0] in_hit_distance,
  input  wire logic [TAG_W-1:0]  in_hit_tag,
  input  wire csgdm_cmd_t        cmd,
  output csgdm_stat_t            stat,
  csgdm_out_if.source            out_ch
);

  // hit list memories
  csgdm_hit_t mem_a [LIST_DEPTH];
  csgdm_hit_t mem_b [LIST_DEPTH];

  logic [CNT_W-1:0]  cnt_a_r, cnt_b_r, a_r, b_r;
  logic              ovf_r;
  csgdm_hit_t        rd_a_r, rd_b_r, hold_r, wr_hit, cur;
  logic              hold_v_r;
  logic              in_first_r, in_second_r, inside_r;
  logic [NOUT_W-1:0] n_r;

  logic              out_valid_r, out_hit_valid_r, out_ovf_r, out_last_r;
  logic signed [DIST_W-1:0] out_dist_r;
  logic [TAG_KEEP-1:0]      out_tag_r;

  logic a_more, b_more, take_a, take_b, nf, ns, now, emit, push, out_busy;

  assign wr_hit.distance = in_hit_distance;
  assign wr_hit.tag      = in_hit_tag[TAG_KEEP-1:0];

  // list writes and registered reads
  always_ff @(posedge clk) begin
    if (cmd.load_first && (cnt_a_r < CNT_W'(LIST_DEPTH)))
      mem_a[cnt_a_r[IDX_W-1:0]] <= wr_hit;
    if (cmd.load_second && (cnt_b_r < CNT_W'(LIST_DEPTH)))
      mem_b[cnt_b_r[IDX_W-1:0]] <= wr_hit;
    rd_a_r <= mem_a[a_r[IDX_W-1:0]];
    rd_b_r <= mem_b[b_r[IDX_W-1:0]];
  end

  // merge step decision
  always_comb begin
    a_more = a_r < cnt_a_r;
    b_more = b_r < cnt_b_r;
    take_a = a_more && (!b_more || (rd_a_r.distance <= rd_b_r.distance));
    take_b = b_more && (!a_more || (rd_b_r.distance <= rd_a_r.distance));
    cur    = take_a ? rd_a_r : rd_b_r;
    nf     = in_first_r ^ take_a;
    ns     = in_second_r ^ take_b;
    now    = nf && !ns;
    emit   = (now != inside_r) && (n_r < NOUT_W'(MAX_OUT));
    push   = emit && hold_v_r;
  end

  assign out_busy      = out_valid_r && !out_ch.ready;
  assign stat.done     = !a_more && !b_more;
  assign stat.stall    = push && out_busy;
  assign stat.out_busy = out_busy;

  // counts, overflow and merge state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_a_r     <= '0;
      cnt_b_r     <= '0;
      ovf_r       <= 1'b0;
      a_r         <= '0;
      b_r         <= '0;
      in_first_r  <= 1'b0;
      in_second_r <= 1'b0;
      inside_r    <= 1'b0;
      n_r         <= '0;
      hold_v_r    <= 1'b0;
    end else begin
      if (cmd.load_first) begin
        if (cnt_a_r < CNT_W'(LIST_DEPTH)) cnt_a_r <= cnt_a_r + 1'b1;
        else ovf_r <= 1'b1;
      end
      if (cmd.load_second) begin
        if (cnt_b_r < CNT_W'(LIST_DEPTH)) cnt_b_r <= cnt_b_r + 1'b1;
        else ovf_r <= 1'b1;
      end
      if (cmd.start) begin
        a_r         <= '0;
        b_r         <= '0;
        in_first_r  <= 1'b0;
        in_second_r <= 1'b0;
        inside_r    <= 1'b0;
        n_r         <= '0;
        hold_v_r    <= 1'b0;
      end
      if (cmd.step) begin
        if (take_a) a_r <= a_r + 1'b1;
        if (take_b) b_r <= b_r + 1'b1;
        in_first_r  <= nf;
        in_second_r <= ns;
        if (now != inside_r) inside_r <= now;
        if (emit) begin
          n_r      <= n_r + 1'b1;
          hold_v_r <= 1'b1;
        end
      end
      if (cmd.finish) begin
        cnt_a_r  <= '0;
        cnt_b_r  <= '0;
        ovf_r    <= 1'b0;
        hold_v_r <= 1'b0;
      end
    end
  end

  // held boundary hit, one behind so the final one can carry last
  always_ff @(posedge clk) begin
    if (cmd.step && emit) hold_r <= cur;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((cmd.step && push) || cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step && push) begin
      out_dist_r      <= hold_r.distance;
      out_tag_r       <= hold_r.tag;
      out_hit_valid_r <= 1'b1;
      out_ovf_r       <= ovf_r;
      out_last_r      <= 1'b0;
    end else if (cmd.finish) begin
      out_dist_r      <= hold_v_r ? hold_r.distance : '0;
      out_tag_r       <= hold_v_r ? hold_r.tag : '0;
      out_hit_valid_r <= hold_v_r;
      out_ovf_r       <= ovf_r;
      out_last_r      <= 1'b1;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.out_distance  = out_dist_r;
  assign out_ch.out_tag       = TAG_W'(out_tag_r);
  assign out_ch.hit_valid     = out_hit_valid_r;
  assign out_ch.overflow_seen = out_ovf_r;
  assign out_ch.last_item     = out_last_r;

endmodule
`default_nettype wire

// ===== hw/rtl/csg_difference_hit_merge.sv =====
// CSG difference merge of two depth-sorted ray hit lists.
// in_ch carries command, hit_distance and hit_tag. Command 0 appends a hit
// to the first list, 1 to the second, 2 starts a merge, 3 is ignored.
// A load into a full list is dropped and sets the overflow flag reported on
// every beat of the next run.
// A run reads both list memories; each step is a read state then a compare
// state and takes the nearer hit, or one hit from each list on equal distance.
// Each list has a single registered read port.
// out_ch beats come from one output register. Each beat is a boundary hit of
// the difference; the final beat of a run has last_item set. A run with no
// boundary gives one beat with hit_valid low. After a run both lists and the
// overflow flag are clear.
// in_ch.ready is high only between runs; loads are taken even while a beat
// waits on out_ch. When out_ch stalls, the merge holds its step until the
// output register is free; no beat is lost.
// rst_n is synchronous and active low: lists empty, flag clear, no beat.
`default_nettype none
`include "assert_macros.svh"
module csg_difference_hit_merge
  import csgdm_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  csgdm_in_if.sink    in_ch,
  csgdm_out_if.source out_ch
);

  csgdm_cmd_t  cmd;
  csgdm_stat_t stat;
  logic        in_ready;

  assign in_ch.ready = in_ready;

  // sequencer
  csgdm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_command (in_ch.command),
    .in_ready   (in_ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  // lists, merge state and output register
  csgdm_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_hit_distance (in_ch.hit_distance),
    .in_hit_tag      (in_ch.hit_tag),
    .cmd             (cmd),
    .stat            (stat),
    .out_ch          (out_ch)
  );

  // checks
  `CSGDM_ASSERT_ONEHOT0(a_cmd_onehot,
    {cmd.load_first, cmd.load_second, cmd.start, cmd.step, cmd.finish},
    "more than one datapath command at once")
  `CSGDM_ASSERT_IMPL(a_step_not_ready, cmd.step || cmd.finish, !in_ch.ready,
    "input ready during a run")
  `CSGDM_ASSERT_NEXT(a_finish_last, cmd.finish, out_ch.valid && out_ch.last_item,
    "run finish did not present a last beat")
  `CSGDM_ASSERT_IMPL(a_stall_busy, stat.stall, out_ch.valid && !out_ch.ready,
    "merge stalled with output free")

endmodule
`default_nettype wire

// ===== verif/tb_csg_difference_hit_merge.sv =====
`timescale 1ns / 100ps

module tb_csg_difference_hit_merge;
  import csgdm_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int RANDOM_ITEMS   = 80;
  localparam int MAX_REPORTS    = 10;
  localparam logic signed [31:0] DIST_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] DIST_MAX = 32'sh7fff_ffff;

  // one boundary beat as seen on the result channel
  typedef struct packed {
    logic signed [31:0] distance;
    logic [15:0]        tag;
    logic               hit_valid;
    logic               overflow_seen;
    logic               last_item;
  } boundary_t;

  // predicts boundary beats of the difference and checks them in order
  class hit_merge_board;
    csgdm_hit_t  list_one[LIST_DEPTH];
    csgdm_hit_t  list_two[LIST_DEPTH];
    int          first_cnt;
    int          second_cnt;
    bit          overflow_flag;
    boundary_t   expected_q[$];
    int          mismatches;

    function new();
      first_cnt     = 0;
      second_cnt    = 0;
      overflow_flag = 1'b0;
      mismatches    = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // walk both lists in distance order and collect boundary changes
    function void merge_difference();
      int        a;
      int        b;
      bit        in_a;
      bit        in_b;
      bit        in_diff;
      bit        now;
      csgdm_hit_t cur;
      boundary_t e;
      boundary_t run_q[$];
      a       = 0;
      b       = 0;
      in_a    = 1'b0;
      in_b    = 1'b0;
      in_diff = 1'b0;
      while (a < first_cnt || b < second_cnt) begin
        if (a < first_cnt && (b >= second_cnt ||
            int'(list_one[a].distance) <= int'(list_two[b].distance))) begin
          cur  = list_one[a];
          in_a = !in_a;
          // equal distances: first list hit taken, both flags toggle
          if (b < second_cnt && list_one[a].distance == list_two[b].distance) begin
            in_b = !in_b;
            b++;
          end
          a++;
        end else begin
          cur  = list_two[b];
          in_b = !in_b;
          b++;
        end
        now = in_a && !in_b;
        if (now != in_diff) begin
          in_diff = now;
          if (run_q.size() < MAX_OUT) begin
            e.distance      = cur.distance;
            e.tag           = 16'(cur.tag);
            e.hit_valid     = 1'b1;
            e.overflow_seen = overflow_flag;
            e.last_item     = 1'b0;
            run_q = {run_q, e};
          end
        end
      end
      // empty difference gives a single marker beat
      if (run_q.size() == 0) begin
        e.distance      = '0;
        e.tag           = '0;
        e.hit_valid     = 1'b0;
        e.overflow_seen = overflow_flag;
        e.last_item     = 1'b0;
        run_q = {run_q, e};
      end
      run_q[run_q.size()-1].last_item = 1'b1;
      expected_q    = {expected_q, run_q};
      first_cnt     = 0;
      second_cnt    = 0;
      overflow_flag = 1'b0;
    endfunction

    // accepted input beat
    function void note_command(csgdm_op_t op, logic signed [31:0] dist_in,
                               logic [15:0] tag);
      csgdm_hit_t h;
      h.distance = dist_in;
      h.tag      = tag[TAG_KEEP-1:0];
      case (op)
        CMD_LOAD_FIRST: begin
          if (first_cnt < LIST_DEPTH) begin
            list_one[first_cnt] = h;
            first_cnt++;
          end else begin
            overflow_flag = 1'b1;
          end
        end
        CMD_LOAD_SECOND: begin
          if (second_cnt < LIST_DEPTH) begin
            list_two[second_cnt] = h;
            second_cnt++;
          end else begin
            overflow_flag = 1'b1;
          end
        end
        CMD_RUN: merge_difference();
        default: ;
      endcase
    endfunction

    // accepted result beat against the oldest prediction
    function void check_boundary(boundary_t got);
      boundary_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected beat dist=%h tag=%h valid=%b ovf=%b last=%b",
                   $realtime, got.distance, got.tag, got.hit_valid, got.overflow_seen,
                   got.last_item);
        return;
      end
      want = expected_q.pop_front();
      if (got.distance != want.distance || got.tag != want.tag ||
          got.hit_valid != want.hit_valid ||
          got.overflow_seen != want.overflow_seen || got.last_item != want.last_item) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: beat differs exp dist=%h tag=%h valid=%b ovf=%b last=%b",
                   $realtime, want.distance, want.tag, want.hit_valid,
                   want.overflow_seen, want.last_item,
                   " / got dist=%h tag=%h valid=%b ovf=%b last=%b",
                   got.distance, got.tag, got.hit_valid, got.overflow_seen,
                   got.last_item);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  csgdm_in_if  in_ch();
  csgdm_out_if out_ch();

  csg_difference_hit_merge DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  hit_merge_board board;
  int             items_sent;
  int             stall_cycles;
  bit             calm;
  bit             drained_once;

  // clock
  always #6 clk = ~clk;

  // result side back-pressure
  always @(negedge clk) begin
    out_ch.ready <= calm || ($urandom_range(0, 99) >= 26);
  end

  // result monitor
  always @(posedge clk) begin
    boundary_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.distance      = out_ch.out_distance;
      got.tag           = out_ch.out_tag;
      got.hit_valid     = out_ch.hit_valid;
      got.overflow_seen = out_ch.overflow_seen;
      got.last_item     = out_ch.last_item;
      board.check_boundary(got);
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("csg_difference_hit_merge: mismatch");
        $finish;
      end
    end
  end

  // offer one input beat, starting and ending at a falling edge
  task automatic send_beat(input csgdm_op_t op, input logic signed [31:0] dist_in,
                           input logic [15:0] tag);
    while (!calm && $urandom_range(0, 99) < 26) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.command      <= op;
    in_ch.hit_distance <= dist_in;
    in_ch.hit_tag      <= tag;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    board.note_command(op, dist_in, tag);
    if (op != CMD_NONE) items_sent++;
    @(negedge clk);
  endtask

  // hold the sender until every predicted beat has come out
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (board.pending() != 0) @(negedge clk);
  endtask

  // two random lists, mostly sorted, then a merge
  task automatic random_run();
    int  n_first;
    int  n_second;
    int  first_d[$];
    int  second_d[$];
    bit  wide;
    n_first  = ($urandom_range(0, 9) == 0) ? $urandom_range(LIST_DEPTH - 1, LIST_DEPTH + 2)
                                           : $urandom_range(0, 6);
    n_second = ($urandom_range(0, 9) == 0) ? $urandom_range(LIST_DEPTH - 1, LIST_DEPTH + 2)
                                           : $urandom_range(0, 6);
    wide = $urandom_range(0, 1);
    repeat (n_first)
      first_d = {first_d, wide ? int'($urandom()) : int'($urandom_range(0, 40)) - 20};
    repeat (n_second) begin
      if (first_d.size() > 0 && $urandom_range(0, 2) == 0)
        second_d = {second_d, first_d[$urandom_range(0, first_d.size() - 1)]};
      else
        second_d = {second_d, wide ? int'($urandom()) : int'($urandom_range(0, 40)) - 20};
    end
    // now and then the lists stay unsorted
    if ($urandom_range(0, 11) != 0) begin
      first_d.sort();
      second_d.sort();
    end
    while (first_d.size() > 0 || second_d.size() > 0) begin
      if ($urandom_range(0, 19) == 0)
        send_beat(CMD_NONE, $urandom(), 16'($urandom_range(0, 65535)));
      if (second_d.size() == 0 || (first_d.size() > 0 && $urandom_range(0, 1) == 1))
        send_beat(CMD_LOAD_FIRST, first_d.pop_front(), 16'($urandom_range(0, 65535)));
      else
        send_beat(CMD_LOAD_SECOND, second_d.pop_front(), 16'($urandom_range(0, 65535)));
    end
    if (!drained_once || $urandom_range(0, 4) == 0) begin
      drain_results();
      drained_once = 1'b1;
    end
    send_beat(CMD_RUN, $urandom(), 16'($urandom_range(0, 65535)));
  endtask

  initial begin
    int start_cnt;
    clk                = 1'b0;
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.command      = CMD_NONE;
    in_ch.hit_distance = '0;
    in_ch.hit_tag      = '0;
    items_sent         = 0;
    calm               = 1'b0;
    drained_once       = 1'b0;
    board              = new();
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // merge with both lists empty
    send_beat(CMD_RUN, DIST_MAX, 16'hffff);
    // unused command is ignored
    send_beat(CMD_NONE, DIST_MIN, 16'h0000);
    // extreme distances, equal distance at the front
    send_beat(CMD_LOAD_FIRST, DIST_MIN, 16'h0000);
    send_beat(CMD_LOAD_SECOND, DIST_MIN, 16'haaaa);
    send_beat(CMD_LOAD_FIRST, DIST_MAX, 16'hffff);
    send_beat(CMD_LOAD_SECOND, 32'sd100, 16'h5555);
    send_beat(CMD_RUN, 32'sd0, 16'h0000);
    // first list only, unsorted
    send_beat(CMD_LOAD_FIRST, 32'sd500, 16'h0001);
    send_beat(CMD_NONE, DIST_MAX, 16'hffff);
    send_beat(CMD_LOAD_FIRST, 32'sd10, 16'h0002);
    send_beat(CMD_LOAD_FIRST, -32'sd7, 16'h0003);
    send_beat(CMD_RUN, DIST_MIN, 16'h1234);
    // second list only gives an empty difference
    send_beat(CMD_LOAD_SECOND, -32'sd1, 16'h00f0);
    send_beat(CMD_LOAD_SECOND, 32'sd65536, 16'h0f00);
    send_beat(CMD_RUN, 32'sd0, 16'h0000);
    // overlapping spans
    send_beat(CMD_LOAD_FIRST, 32'sd0, 16'h8000);
    send_beat(CMD_LOAD_SECOND, 32'sd5, 16'h4000);
    send_beat(CMD_LOAD_FIRST, 32'sd10, 16'h2000);
    send_beat(CMD_LOAD_SECOND, 32'sd20, 16'h1000);
    send_beat(CMD_RUN, 32'sd0, 16'h0000);

    // random lists, with one stretch of full throughput on both sides
    start_cnt = items_sent;
    while (items_sent - start_cnt < RANDOM_ITEMS) begin
      calm = (items_sent - start_cnt >= 40) && (items_sent - start_cnt < 65);
      random_run();
    end
    calm = 1'b0;
    in_ch.valid <= 1'b0;

    // wait out the remaining beats
    while (board.pending() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("csg_difference_hit_merge: match");
    end else begin
      $display("csg_difference_hit_merge: mismatch");
    end
    $finish;
  end

endmodule
